// ----- hw/rtl/adf_pkg.sv -----
package adf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_UUID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRUCTURE_TYPE = 1'b1;

    localparam logic [15:0] SERVICE_UUID_RST   = 16'hFCD2;
    localparam logic [7:0]  STRUCTURE_TYPE_RST = 8'h16;

    // type byte plus the two UUID bytes
    localparam logic [7:0] UUID_HDR_LEN = 8'd3;

    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_TYPE    = 3'd1,
        PH_UUID_LO = 3'd2,
        PH_UUID_HI = 3'd3,
        PH_BODY    = 3'd4,
        PH_STOP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic       found;
        logic [7:0] payload_offset;
        logic [7:0] payload_length;
    } result_t;

endpackage

// ----- hw/rtl/adf_in_stage.sv -----
module adf_in_stage
    import adf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    input  logic       take,
    output logic       valid,
    output logic [7:0] adv_byte,
    output logic       last_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_byte;
            last_reg <= s_last;
        end
    end

    assign valid     = valid_reg;
    assign adv_byte  = byte_reg;
    assign last_byte = last_reg;

endmodule

// ----- hw/rtl/adf_parser.sv -----
module adf_parser
    import adf_pkg::*;
#(
    parameter int MAX_ADV_BYTES = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  adv_byte,
    input  logic        last_byte,
    input  logic [15:0] service_uuid,
    input  logic [7:0]  structure_type,
    output result_t     result
);

    localparam int PW = $clog2(MAX_ADV_BYTES + 1);
    localparam int XW = (PW > 8) ? PW : 8;

    phase_t         phase_reg, phase_next, phase_w;
    logic [PW-1:0]  pos_reg, pos_next, pos_w;
    logic [7:0]     left_reg, left_next, left_w;
    logic [7:0]     flen_reg, flen_next, flen_w;
    logic [7:0]     ulo_reg, ulo_next, ulo_w;
    logic           cand_reg, cand_next, cand_w;
    logic           mfound_reg, mfound_next, mfound_w;
    logic [7:0]     moff_reg, moff_next, moff_w;
    logic [7:0]     mlen_reg, mlen_next, mlen_w;
    logic           body_byte;
    logic [XW-1:0]  pos_ext;

    assign pos_ext = XW'(pos_reg);

    always_comb
    begin
        phase_w   = phase_reg;
        pos_w     = pos_reg;
        left_w    = left_reg;
        flen_w    = flen_reg;
        ulo_w     = ulo_reg;
        cand_w    = cand_reg;
        mfound_w  = mfound_reg;
        moff_w    = moff_reg;
        mlen_w    = mlen_reg;
        body_byte = 1'b0;

        if (step && (pos_reg < PW'(MAX_ADV_BYTES)))
        begin
            pos_w = pos_reg + PW'(1);
            case (phase_reg)
                PH_LEN:
                begin
                    if (adv_byte == 8'd0)
                    begin
                        phase_w = PH_STOP;
                    end
                    else
                    begin
                        flen_w  = adv_byte;
                        left_w  = adv_byte;
                        phase_w = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    cand_w = 1'b0;
                    left_w = left_reg - 8'd1;
                    if (left_w == 8'd0)
                        phase_w = PH_LEN;
                    else if (adv_byte == structure_type && flen_reg >= UUID_HDR_LEN)
                        phase_w = PH_UUID_LO;
                    else
                        phase_w = PH_BODY;
                end
                PH_UUID_LO:
                begin
                    ulo_w     = adv_byte;
                    left_w    = left_reg - 8'd1;
                    phase_w   = PH_UUID_HI;
                    body_byte = 1'b1;
                end
                PH_UUID_HI:
                begin
                    left_w = left_reg - 8'd1;
                    if ({adv_byte, ulo_reg} == service_uuid)
                    begin
                        cand_w = 1'b1;
                        moff_w = 8'(pos_ext + XW'(1));
                        mlen_w = flen_reg - UUID_HDR_LEN;
                    end
                    phase_w   = PH_BODY;
                    body_byte = 1'b1;
                end
                PH_BODY:
                begin
                    left_w    = left_reg - 8'd1;
                    body_byte = 1'b1;
                end
                default:
                begin
                end
            endcase

            // structure complete
            if (body_byte && left_w == 8'd0)
            begin
                if (cand_w)
                begin
                    mfound_w = 1'b1;
                    phase_w  = PH_STOP;
                end
                else
                begin
                    phase_w = PH_LEN;
                end
                cand_w = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.found          = mfound_w;
        result.payload_offset = mfound_w ? moff_w : 8'd0;
        result.payload_length = mfound_w ? mlen_w : 8'd0;
    end

    always_comb
    begin
        if (step && last_byte)
        begin
            phase_next  = PH_LEN;
            pos_next    = '0;
            left_next   = '0;
            flen_next   = '0;
            ulo_next    = '0;
            cand_next   = 1'b0;
            mfound_next = 1'b0;
            moff_next   = '0;
            mlen_next   = '0;
        end
        else
        begin
            phase_next  = phase_w;
            pos_next    = pos_w;
            left_next   = left_w;
            flen_next   = flen_w;
            ulo_next    = ulo_w;
            cand_next   = cand_w;
            mfound_next = mfound_w;
            moff_next   = moff_w;
            mlen_next   = mlen_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            pos_reg    <= '0;
            left_reg   <= '0;
            flen_reg   <= '0;
            ulo_reg    <= '0;
            cand_reg   <= 1'b0;
            mfound_reg <= 1'b0;
            moff_reg   <= '0;
            mlen_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            flen_reg   <= flen_next;
            ulo_reg    <= ulo_next;
            cand_reg   <= cand_next;
            mfound_reg <= mfound_next;
            moff_reg   <= moff_next;
            mlen_reg   <= mlen_next;
        end
    end

endmodule

// ----- hw/rtl/adf_out_stage.sv -----
module adf_out_stage
    import adf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ----- hw/rtl/adv_service_data_finder.sv -----
// Advertising-data service-data finder.
// Slave stream: one advertising byte per transaction, s_tlast on the final
// byte. Master stream: one transaction per advertisement, sent for the byte
// flagged s_tlast: m_tuser = found, m_tdata = payload offset and length.
// Configuration: cfg_we/cfg_addr/cfg_data; index 0 = service UUID,
// index 1 = AD structure type. Write only while the block is idle.
// Throughput: one byte per cycle, sustained, with no gaps between
// advertisements, while the result register can take each result. Each
// byte passes an input register, then the parser updates its state and,
// on the last byte, loads the result register that drives m_tvalid.
// Bytes beyond MAX_ADV_BYTES are ignored; a result is still produced.
// When m_tready is low and a result waits, non-last bytes keep flowing; a
// last byte waits in the input register and s_tready drops once it is full.
// Reset: no result pending, parser expects a length byte, registers return
// to UUID 0xFCD2 and type 0x16.
module adv_service_data_finder
    import adf_pkg::*;
#(
    parameter int MAX_ADV_BYTES = 255
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] adv_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] payload_offset, [15:8] payload_length
    output logic                  m_tuser,   // [0] found
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] uuid_reg;
    logic [7:0]  stype_reg;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        take;
    logic        can_load;
    result_t     result;
    result_t     m_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_reg  <= SERVICE_UUID_RST;
            stype_reg <= STRUCTURE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SERVICE_UUID:   uuid_reg  <= cfg_data;
                CFG_STRUCTURE_TYPE: stype_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign take = in_valid && (!in_last || can_load);

    adf_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_byte    (s_tdata),
        .s_last    (s_tlast),
        .take      (take),
        .valid     (in_valid),
        .adv_byte  (in_byte),
        .last_byte (in_last)
    );

    adf_parser #(
        .MAX_ADV_BYTES (MAX_ADV_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (take),
        .adv_byte       (in_byte),
        .last_byte      (in_last),
        .service_uuid   (uuid_reg),
        .structure_type (stype_reg),
        .result         (result)
    );

    adf_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && in_last),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tuser = m_result.found;
    assign m_tdata = {m_result.payload_length, m_result.payload_offset};

endmodule
